// File: hdl/flea_pkg.sv
// Shared types, constants and helper functions for the FLEA-style generator.
// No dependencies; used by the controller, the datapath and the top level.
package flea_pkg;

    localparam logic [31:0] GOLDEN_WORD = 32'h9e3779b9;

    // Request kinds carried by s_req_type
    localparam logic [1:0] REQ_INIT = 2'd0;
    localparam logic [1:0] REQ_LOAD = 2'd1;
    localparam logic [1:0] REQ_MIX  = 2'd2;
    localparam logic [1:0] REQ_DRAW = 2'd3;

    typedef struct packed {
        logic [4:0] r1;
        logic [4:0] r2;
        logic [4:0] r3;
    } rot_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic idx_clr;    // restart the pass index
        logic clr_wr;     // write reset values at the pass index, advance index
        logic init_chain; // load chain words, read position and selector
        logic load_wr;    // write seed word into the mixing table
        logic rd_b;       // table read address: 1 = chain b, 0 = chain d
        logic upd;        // table step: update entry, advance b and c
        logic fin;        // finish step: new d into buffer, advance index
        logic sel_upd;    // take next rotation triple from c
        logic pos_inc;    // advance read position
        logic out_load;   // capture buffered word into the output register
    } flea_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic idx_last;
        logic pos_last;
        logic out_free;
    } flea_stat_t;

    function automatic rot_t rot_triple(logic [1:0] sel);
        rot_t r;
        unique case (sel)
            2'd0:    r = '{r1: 5'd30, r2: 5'd13, r3: 5'd24};
            2'd1:    r = '{r1: 5'd5,  r2: 5'd19, r3: 5'd20};
            2'd2:    r = '{r1: 5'd21, r2: 5'd4,  r3: 5'd10};
            default: r = '{r1: 5'd29, r2: 5'd15, r3: 5'd6};
        endcase
        return r;
    endfunction

    function automatic logic [31:0] rotl32(logic [31:0] x, logic [4:0] k);
        logic [5:0] rk;
        rk = 6'd32 - {1'b0, k};
        // a zero amount shifts right by 32, which gives zero
        return (x << k) | (x >> rk);
    endfunction

endpackage

// File: hdl/flea_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module flea_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: hdl/flea_dp.sv
// Datapath: mixing table and output buffer RAMs, chain words, pass index,
// read position, rotation selector and output register. Uses flea_pkg, flea_ram.
module flea_dp #(
    parameter int TABLE_WORDS = 256
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  flea_pkg::flea_cmd_t  cmd,
    output flea_pkg::flea_stat_t stat,
    input  logic [7:0]         s_word_index,
    input  logic [31:0]        s_seed_word,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [31:0]        m_random_word
);
    import flea_pkg::*;

    localparam int ADDR_W = $clog2(TABLE_WORDS);
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(TABLE_WORDS - 1);

    logic [31:0] b_reg, b_next;
    logic [31:0] c_reg, c_next;
    logic [31:0] d_reg, d_next;
    logic [31:0] t_reg, t_next;
    logic [ADDR_W-1:0] idx_reg, idx_next;
    logic [ADDR_W-1:0] pos_reg, pos_next;
    logic [1:0]  sel_reg, sel_next;
    logic        mv_reg, mv_next;
    logic [31:0] mw_reg, mw_next;

    logic              tbl_we;
    logic [ADDR_W-1:0] tbl_waddr, tbl_raddr;
    logic [31:0]       tbl_wdata, tbl_rdata;
    logic              buf_we;
    logic [ADDR_W-1:0] buf_waddr;
    logic [31:0]       buf_wdata, buf_rdata;

    logic [31:0] widx32;
    rot_t        rot;
    logic [31:0] t_now;
    logic [31:0] d_new;

    assign widx32 = {24'd0, s_word_index};
    assign rot    = rot_triple(sel_reg);
    assign t_now  = tbl_rdata - rotl32(b_reg, rot.r1);
    assign d_new  = t_reg + tbl_rdata;

    flea_ram #(.WIDTH(32), .DEPTH(TABLE_WORDS)) u_tbl (
        .aclk  (aclk),
        .we    (tbl_we),
        .waddr (tbl_waddr),
        .wdata (tbl_wdata),
        .raddr (tbl_raddr),
        .rdata (tbl_rdata)
    );

    flea_ram #(.WIDTH(32), .DEPTH(TABLE_WORDS)) u_buf (
        .aclk  (aclk),
        .we    (buf_we),
        .waddr (buf_waddr),
        .wdata (buf_wdata),
        .raddr (pos_reg),
        .rdata (buf_rdata)
    );

    always_comb begin
        tbl_we    = 1'b0;
        tbl_waddr = idx_reg;
        tbl_wdata = GOLDEN_WORD;
        if (cmd.clr_wr) begin
            tbl_we = 1'b1;
        end else if (cmd.load_wr) begin
            tbl_we    = 1'b1;
            tbl_waddr = widx32[ADDR_W-1:0];
            tbl_wdata = s_seed_word;
        end else if (cmd.upd) begin
            tbl_we    = 1'b1;
            tbl_waddr = d_reg[ADDR_W-1:0];
            tbl_wdata = b_reg ^ rotl32(c_reg, rot.r2);
        end
        tbl_raddr = cmd.rd_b ? b_reg[ADDR_W-1:0] : d_reg[ADDR_W-1:0];

        buf_we    = cmd.clr_wr | cmd.fin;
        buf_waddr = idx_reg;
        buf_wdata = cmd.fin ? d_new : 32'd0;
    end

    always_comb begin
        b_next   = b_reg;
        c_next   = c_reg;
        d_next   = d_reg;
        t_next   = t_reg;
        idx_next = idx_reg;
        pos_next = pos_reg;
        sel_next = sel_reg;
        mv_next  = mv_reg;
        mw_next  = mw_reg;

        if (cmd.idx_clr) begin
            idx_next = '0;
        end else if (cmd.clr_wr || cmd.fin) begin
            idx_next = idx_reg + 1'b1;
        end
        if (cmd.init_chain) begin
            b_next   = GOLDEN_WORD;
            c_next   = GOLDEN_WORD;
            d_next   = GOLDEN_WORD;
            pos_next = '0;
            sel_next = 2'd0;
        end
        if (cmd.upd) begin
            t_next = t_now;
            b_next = c_reg + rotl32(d_reg, rot.r3);
            c_next = d_reg + t_now;
        end
        if (cmd.fin) begin
            d_next = d_new;
        end
        if (cmd.sel_upd) begin
            sel_next = c_reg[1:0];
        end
        if (cmd.pos_inc) begin
            pos_next = pos_reg + 1'b1;
        end

        if (cmd.out_load) begin
            mv_next = 1'b1;
            mw_next = buf_rdata;
        end else if (m_ready) begin
            mv_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg <= '0;
            pos_reg <= '0;
            sel_reg <= 2'd0;
            mv_reg  <= 1'b0;
        end else begin
            idx_reg <= idx_next;
            pos_reg <= pos_next;
            sel_reg <= sel_next;
            mv_reg  <= mv_next;
        end
    end

    always_ff @(posedge aclk) begin
        b_reg  <= b_next;
        c_reg  <= c_next;
        d_reg  <= d_next;
        t_reg  <= t_next;
        mw_reg <= mw_next;
    end

    assign stat.idx_last = (idx_reg == LAST_ADDR);
    assign stat.pos_last = (pos_reg == LAST_ADDR);
    assign stat.out_free = !mv_reg || m_ready;

    assign m_valid       = mv_reg;
    assign m_random_word = mw_reg;

endmodule

// File: hdl/flea_ctrl.sv
// Controller: request handshake, clearing pass, refill sequencing and
// discard counting. Uses flea_pkg; drives the datapath by command struct.
module flea_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [1:0]           s_req_type,
    input  logic [15:0]          s_discard_count,
    input  flea_pkg::flea_stat_t stat,
    output flea_pkg::flea_cmd_t  cmd
);
    import flea_pkg::*;

    localparam logic [2:0] ST_CLR  = 3'd0;
    localparam logic [2:0] ST_IDLE = 3'd1;
    localparam logic [2:0] ST_DRAW = 3'd2;
    localparam logic [2:0] ST_RD_D = 3'd3;
    localparam logic [2:0] ST_UPD  = 3'd4;
    localparam logic [2:0] ST_RD_B = 3'd5;
    localparam logic [2:0] ST_FIN  = 3'd6;
    localparam logic [2:0] ST_DISC = 3'd7;

    logic [2:0]  state_reg, state_next;
    logic [15:0] cnt_reg, cnt_next;
    logic        accept;

    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        cmd        = '0;

        unique case (state_reg)
            ST_CLR: begin
                cmd.clr_wr = 1'b1;
                if (stat.idx_last) begin
                    cmd.init_chain = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    unique case (s_req_type)
                        REQ_INIT: begin
                            cmd.idx_clr = 1'b1;
                            state_next  = ST_CLR;
                        end
                        REQ_LOAD: begin
                            cmd.load_wr = 1'b1;
                        end
                        REQ_MIX: begin
                            cmd.idx_clr = 1'b1;
                            cnt_next    = s_discard_count;
                            state_next  = ST_RD_D;
                        end
                        default: begin
                            cnt_next   = 16'd0;
                            state_next = ST_DRAW;
                        end
                    endcase
                end
            end
            ST_DRAW: begin
                // hold the buffered word until the output register frees up
                if (stat.out_free) begin
                    cmd.out_load = 1'b1;
                    cmd.pos_inc  = 1'b1;
                    if (stat.pos_last) begin
                        cmd.idx_clr = 1'b1;
                        state_next  = ST_RD_D;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_RD_D: begin
                state_next = ST_UPD;
            end
            ST_UPD: begin
                cmd.upd    = 1'b1;
                state_next = ST_RD_B;
            end
            ST_RD_B: begin
                cmd.rd_b   = 1'b1;
                state_next = ST_FIN;
            end
            ST_FIN: begin
                cmd.fin = 1'b1;
                if (stat.idx_last) begin
                    cmd.sel_upd = 1'b1;
                    state_next  = ST_DISC;
                end else begin
                    state_next = ST_RD_D;
                end
            end
            default: begin
                // drop one draw per cycle; refill again on wrap
                if (cnt_reg == 16'd0) begin
                    state_next = ST_IDLE;
                end else begin
                    cnt_next    = cnt_reg - 16'd1;
                    cmd.pos_inc = 1'b1;
                    if (stat.pos_last) begin
                        cmd.idx_clr = 1'b1;
                        state_next  = ST_RD_D;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLR;
            cnt_reg   <= 16'd0;
        end else begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

// File: hdl/flea_style_prng_rotation_switch.sv
// Top level of the FLEA-style 32-bit generator with rotation switching.
// Depends on flea_pkg, flea_ctrl, flea_dp and flea_ram.
//
//   channel | ports                                   | carries
//   --------+-----------------------------------------+---------------------------
//   s_      | s_valid/s_ready, s_req_type,            | one request item
//           | s_word_index, s_seed_word,              |
//           | s_discard_count                         |
//   m_      | m_valid/m_ready, m_random_word          | one word per draw item
//
// A load is taken in the idle state; a draw goes through the draw state. A refill pass
// steps through the whole table, each step running the read-d, update, read-b and finish
// states in turn (set by the single read port of the table RAM), and follows every
// TABLE_WORDS draws. Mix runs one pass and then the discarded draws, plus any passes
// on wrap. Reset and reinitialise run a clearing pass over all TABLE_WORDS entries with
// s_ready low. The output register holds a result while the next item is
// taken; a draw waits only if the previous word has not yet been taken.
// TABLE_WORDS must be a power of two.
module flea_style_prng_rotation_switch #(
    parameter int TABLE_WORDS = 256
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_req_type,
    input  logic [7:0]  s_word_index,
    input  logic [31:0] s_seed_word,
    input  logic [15:0] s_discard_count,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_random_word
);
    import flea_pkg::*;

    flea_cmd_t  cmd;
    flea_stat_t stat;

    flea_ctrl u_ctrl (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_req_type      (s_req_type),
        .s_discard_count (s_discard_count),
        .stat            (stat),
        .cmd             (cmd)
    );

    flea_dp #(.TABLE_WORDS(TABLE_WORDS)) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .stat          (stat),
        .s_word_index  (s_word_index),
        .s_seed_word   (s_seed_word),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_random_word (m_random_word)
    );

endmodule

// File: tb/flea_style_prng_rotation_switch_test.sv
// Self-checking testbench for the FLEA-style generator with rotation switching.
// Depends on flea_pkg and the RTL top level; predicts every drawn word in-line
// and checks the result channel while both channels idle and stall at random.
module flea_style_prng_rotation_switch_test;
    import flea_pkg::*;

    localparam int TW          = 256;
    localparam int ITEM_TARGET = 550;
    localparam int LONG_HOLD   = 600;
    // one refill pass plus margin
    localparam int TAIL_CYCLES = 4 * TW + 64;
    // worst run is dominated by the full-count mix; allow well over
    localparam int CYCLE_LIMIT = 3_000_000;

    typedef struct packed {
        logic [1:0]  kind;
        logic [7:0]  idx;
        logic [31:0] word;
        logic [15:0] count;
        logic        drain_first;
    } req_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_req_type = REQ_INIT;
    logic [7:0]  s_word_index = 8'd0;
    logic [31:0] s_seed_word = 32'd0;
    logic [15:0] s_discard_count = 16'd0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [31:0] m_random_word;

    flea_style_prng_rotation_switch #(
        .TABLE_WORDS(TW)
    ) u_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_req_type     (s_req_type),
        .s_word_index   (s_word_index),
        .s_seed_word    (s_seed_word),
        .s_discard_count(s_discard_count),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_random_word  (m_random_word)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    // Generator state as predicted
    logic [31:0] mix_tbl   [TW];
    logic [31:0] out_words [TW];
    logic [31:0] ch_b, ch_c, ch_d;
    int          rd_pos;
    logic [1:0]  rot_sel;

    req_t        req_queue[$];
    logic [31:0] draw_expect[$];
    int          err_count = 0;

    function automatic rot_t rot_amounts(logic [1:0] sel);
        rot_t a;
        case (sel)
            2'd0:    begin a.r1 = 5'd30; a.r2 = 5'd13; a.r3 = 5'd24; end
            2'd1:    begin a.r1 = 5'd5;  a.r2 = 5'd19; a.r3 = 5'd20; end
            2'd2:    begin a.r1 = 5'd21; a.r2 = 5'd4;  a.r3 = 5'd10; end
            default: begin a.r1 = 5'd29; a.r2 = 5'd15; a.r3 = 5'd6;  end
        endcase
        return a;
    endfunction

    function automatic logic [31:0] rotate_left(logic [31:0] x, logic [4:0] k);
        if (k == 5'd0) return x;
        return (x << k) | (x >> (32 - k));
    endfunction

    function automatic void gen_reset();
        int i;
        for (i = 0; i < TW; i++) begin
            mix_tbl[i]   = GOLDEN_WORD;
            out_words[i] = 32'd0;
        end
        ch_b    = GOLDEN_WORD;
        ch_c    = GOLDEN_WORD;
        ch_d    = GOLDEN_WORD;
        rd_pos  = 0;
        rot_sel = 2'd0;
    endfunction

    function automatic void refill_pass();
        rot_t        amt;
        logic [31:0] t;
        logic [7:0]  slot;
        int          i;
        amt = rot_amounts(rot_sel);
        for (i = 0; i < TW; i++) begin
            slot          = ch_d[7:0];
            t             = mix_tbl[slot] - rotate_left(ch_b, amt.r1);
            mix_tbl[slot] = ch_b ^ rotate_left(ch_c, amt.r2);
            ch_b          = ch_c + rotate_left(ch_d, amt.r3);
            ch_c          = ch_d + t;
            // extra lookup addressed by the new b
            ch_d          = t + mix_tbl[ch_b[7:0]];
            out_words[i]  = ch_d;
        end
        rot_sel = ch_c[1:0];
    endfunction

    function automatic logic [31:0] draw_word();
        logic [31:0] w;
        w = out_words[rd_pos];
        rd_pos++;
        if (rd_pos >= TW) begin
            refill_pass();
            rd_pos = 0;
        end
        return w;
    endfunction

    function automatic void apply_request(req_t r);
        int i;
        case (r.kind)
            REQ_INIT: gen_reset();
            REQ_LOAD: mix_tbl[r.idx] = r.word;
            REQ_MIX: begin
                refill_pass();
                for (i = 0; i < int'(r.count); i++) void'(draw_word());
            end
            default: draw_expect.push_back(draw_word());
        endcase
    endfunction

    task automatic add_req(logic [1:0] kind, logic [7:0] idx, logic [31:0] word,
                           logic [15:0] count, logic drain_first);
        req_t r;
        r.kind        = kind;
        r.idx         = idx;
        r.word        = word;
        r.count       = count;
        r.drain_first = drain_first;
        req_queue.push_back(r);
    endtask

    // Request driver
    req_t cur_req;
    req_t nxt_req;
    int   tx_wait = 0;
    bit   tx_calm = 1'b0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            tx_wait = 0;
        end else begin
            if (s_valid && s_ready) apply_request(cur_req);
            if (!s_valid || s_ready) begin
                if (tx_wait != 0) begin
                    tx_wait--;
                    s_valid <= 1'b0;
                end else if (req_queue.size() != 0 &&
                             !(req_queue[0].drain_first && draw_expect.size() != 0)) begin
                    nxt_req = req_queue.pop_front();
                    cur_req         <= nxt_req;
                    s_req_type      <= nxt_req.kind;
                    s_word_index    <= nxt_req.idx;
                    s_seed_word     <= nxt_req.word;
                    s_discard_count <= nxt_req.count;
                    s_valid         <= 1'b1;
                    if ($urandom_range(0, 29) == 0) tx_calm = !tx_calm;
                    tx_wait = tx_calm ? 0 : int'($urandom_range(0, 16));
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor
    int          rx_wait = 0;
    int          words_seen = 0;
    bit          rx_calm = 1'b0;
    logic [31:0] want;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            rx_wait = 0;
        end else if (m_valid && m_ready) begin
            if (draw_expect.size() == 0) begin
                $display("%0t: unexpected item, expected none, got random_word %08h",
                         $time, m_random_word);
                err_count++;
            end else begin
                want = draw_expect.pop_front();
                if (m_random_word !== want) begin
                    $display("%0t: random_word mismatch, expected %08h, got %08h",
                             $time, want, m_random_word);
                    err_count++;
                end
            end
            words_seen++;
            if ($urandom_range(0, 29) == 0) rx_calm = !rx_calm;
            // hold off once for long enough to back up the input
            if (words_seen == 150) rx_wait = LONG_HOLD;
            else rx_wait = rx_calm ? 0 : int'($urandom_range(0, 16));
            m_ready <= (rx_wait == 0);
        end else if (rx_wait != 0) begin
            rx_wait--;
            if (rx_wait == 0) m_ready <= 1'b1;
        end else begin
            m_ready <= 1'b1;
        end
    end

    int cycle_count = 0;

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        int n_items;
        int pick;
        int n_loads;
        gen_reset();

        // draws before seeding return the cleared buffer
        add_req(REQ_DRAW, 8'h00, 32'h0, 16'h0, 1'b0);
        add_req(REQ_DRAW, 8'hff, 32'hffffffff, 16'hffff, 1'b0);
        add_req(REQ_LOAD, 8'h00, 32'hffffffff, 16'h0, 1'b0);
        add_req(REQ_LOAD, 8'hff, 32'h00000000, 16'hffff, 1'b0);
        add_req(REQ_LOAD, 8'h5a, 32'h01234567, 16'h0, 1'b0);
        // zero discards: pass only
        add_req(REQ_MIX, 8'h00, 32'h0, 16'd0, 1'b0);
        add_req(REQ_DRAW, 8'h00, 32'h0, 16'h0, 1'b0);
        add_req(REQ_DRAW, 8'h00, 32'h0, 16'h0, 1'b0);
        add_req(REQ_DRAW, 8'h00, 32'h0, 16'h0, 1'b0);
        // full discard count wraps the buffer many times
        add_req(REQ_MIX, 8'hff, 32'hffffffff, 16'hffff, 1'b0);
        add_req(REQ_DRAW, 8'h00, 32'h0, 16'h0, 1'b0);
        add_req(REQ_DRAW, 8'h00, 32'h0, 16'h0, 1'b0);
        add_req(REQ_LOAD, 8'h80, 32'hdeadbeef, 16'h0, 1'b0);
        add_req(REQ_MIX, 8'h00, 32'h0, 16'd1, 1'b0);
        add_req(REQ_DRAW, 8'h00, 32'h0, 16'h0, 1'b0);
        // reinitialise mid-stream, then draw the cleared buffer again
        add_req(REQ_INIT, 8'h3c, 32'h55aa55aa, 16'h1234, 1'b0);
        add_req(REQ_DRAW, 8'h00, 32'h0, 16'h0, 1'b0);
        add_req(REQ_DRAW, 8'h00, 32'h0, 16'h0, 1'b0);
        add_req(REQ_LOAD, 8'ha5, 32'h80000001, 16'h0, 1'b0);
        add_req(REQ_MIX, 8'h00, 32'h0, 16'd300, 1'b0);
        add_req(REQ_DRAW, 8'h00, 32'h0, 16'h0, 1'b0);
        add_req(REQ_DRAW, 8'h00, 32'h0, 16'h0, 1'b0);
        n_items = req_queue.size();

        // pause the sender until every word so far has come back
        add_req(REQ_DRAW, 8'($urandom_range(0, 255)), $urandom(), 16'($urandom()), 1'b1);
        n_items++;
        while (n_items < ITEM_TARGET) begin
            pick = int'($urandom_range(0, 99));
            if (pick < 5) begin
                // reseed: init, a few loads, mix with a short discard
                add_req(REQ_INIT, 8'($urandom_range(0, 255)), $urandom(),
                        16'($urandom()), 1'b0);
                n_loads = int'($urandom_range(1, 8));
                repeat (n_loads)
                    add_req(REQ_LOAD, 8'($urandom_range(0, 255)), $urandom(),
                            16'($urandom()), 1'b0);
                add_req(REQ_MIX, 8'($urandom_range(0, 255)), $urandom(),
                        16'($urandom_range(0, 600)), 1'b0);
                n_items += n_loads + 2;
            end else if (pick < 9) begin
                add_req(REQ_LOAD, 8'($urandom_range(0, 255)), $urandom(),
                        16'($urandom()), 1'b0);
                n_items++;
            end else if (pick < 12) begin
                add_req(REQ_MIX, 8'($urandom_range(0, 255)), $urandom(),
                        16'($urandom_range(0, 600)), 1'b0);
                n_items++;
            end else if (pick < 13) begin
                add_req(REQ_INIT, 8'($urandom_range(0, 255)), $urandom(),
                        16'($urandom()), 1'b0);
                n_items++;
            end else begin
                add_req(REQ_DRAW, 8'($urandom_range(0, 255)), $urandom(), 16'($urandom()),
                        ($urandom_range(0, 49) == 0));
                n_items++;
            end
        end

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        while (req_queue.size() != 0 || s_valid || draw_expect.size() != 0)
            @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        if (err_count == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule
